// ===== rtl/core/apsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apsc_pkg - shared types and constants of the arm position state controller
// Beat payloads, configuration struct, command codes and fixed-point constants.
// ----------------------------------------------------------------------------
package apsc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_MIN_ANGLE     = 3'd0;
  localparam logic [2:0] CFG_MAX_ANGLE     = 3'd1;
  localparam logic [2:0] CFG_LIFT_BLOCK    = 3'd2;
  localparam logic [2:0] CFG_ANGLE_TOL     = 3'd3;
  localparam logic [2:0] CFG_SPEED_TOL     = 3'd4;
  localparam logic [2:0] CFG_MANUAL_DEADBD = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Command modes (code 3 carries no meaning)
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_AUTO     = 2'd1;
  localparam logic [1:0] MODE_MANUAL   = 2'd2;

  // Command status codes
  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED  = 2'd1;
  localparam logic [1:0] STATUS_REJECTED  = 2'd2;
  localparam logic [1:0] STATUS_UNCHANGED = 2'd3;

  // Q14 full power
  localparam logic [16:0] FULL_POWER = 17'd16384;

  // Lift blocking zone bounds, 1/16 degree
  localparam logic signed [12:0] ZONE_LOW  = -13'sd1440;
  localparam logic signed [12:0] ZONE_HIGH = 13'sd480;

  // Reset goal angle
  localparam logic signed [12:0] RESET_GOAL = -13'sd1440;

  // Hold power: round(num / 1125); reciprocal exact for magnitudes below 2^24
  localparam logic [23:0] HOLD_HALF  = 24'd562;
  localparam logic [24:0] HOLD_RECIP = 25'd30541990;
  localparam int          HOLD_SHIFT = 35;

  // Move power: round(diff * 1024 / 25); reciprocal exact below 2^24
  localparam logic [23:0] MOVE_HALF  = 24'd12;
  localparam logic [24:0] MOVE_RECIP = 25'd21474837;
  localparam int          MOVE_SHIFT = 29;

  typedef struct packed {
    logic signed [12:0] min_angle;
    logic signed [12:0] max_angle;
    logic        [11:0] lift_block_height;
    logic        [9:0]  angle_tolerance;
    logic        [14:0] speed_tolerance;
    logic        [14:0] manual_deadband;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic        [1:0]  cmd_mode;
    logic signed [15:0] power_limit;
    logic signed [12:0] goal_angle;
    logic signed [12:0] arm_angle;
    logic signed [15:0] arm_speed;
    logic        [11:0] lift_height;
  } item_t;

  typedef struct packed {
    logic signed [15:0] motor_power;
    logic               power_changed;
    logic               at_goal;
    logic        [1:0]  ctrl_state;
    logic        [1:0]  cmd_status;
  } result_t;

endpackage

// ===== rtl/core/apsc_stream_if.sv =====
// ----------------------------------------------------------------------------
// apsc_stream_if - valid/ready channels of the arm position state controller
// Input channel carries command and tick beats, output channel result beats.
// ----------------------------------------------------------------------------
interface apsc_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic        [1:0]  cmd_mode;
  logic signed [15:0] power_limit;
  logic signed [12:0] goal_angle;
  logic signed [12:0] arm_angle;
  logic signed [15:0] arm_speed;
  logic        [11:0] lift_height;

  modport source (
    output valid, req_type, cmd_mode, power_limit, goal_angle, arm_angle,
           arm_speed, lift_height,
    input  ready
  );
  modport sink (
    input  valid, req_type, cmd_mode, power_limit, goal_angle, arm_angle,
           arm_speed, lift_height,
    output ready
  );
endinterface

interface apsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motor_power;
  logic               power_changed;
  logic               at_goal;
  logic        [1:0]  ctrl_state;
  logic        [1:0]  cmd_status;

  modport source (
    output valid, motor_power, power_changed, at_goal, ctrl_state, cmd_status,
    input  ready
  );
  modport sink (
    input  valid, motor_power, power_changed, at_goal, ctrl_state, cmd_status,
    output ready
  );
endinterface

// ===== rtl/core/apsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// apsc_cfg_regs - configuration register file
// Write-only registers selected by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module apsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [apsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output apsc_pkg::cfg_t                     cfg
);

  apsc_pkg::cfg_t cfg_r;
  apsc_pkg::cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        apsc_pkg::CFG_MIN_ANGLE:     cfg_nxt.min_angle         = cfg_wdata[12:0];
        apsc_pkg::CFG_MAX_ANGLE:     cfg_nxt.max_angle         = cfg_wdata[12:0];
        apsc_pkg::CFG_LIFT_BLOCK:    cfg_nxt.lift_block_height = cfg_wdata[11:0];
        apsc_pkg::CFG_ANGLE_TOL:     cfg_nxt.angle_tolerance   = cfg_wdata[9:0];
        apsc_pkg::CFG_SPEED_TOL:     cfg_nxt.speed_tolerance   = cfg_wdata[14:0];
        apsc_pkg::CFG_MANUAL_DEADBD: cfg_nxt.manual_deadband   = cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_angle         <= -13'sd1440;
      cfg_r.max_angle         <= 13'sd1440;
      cfg_r.lift_block_height <= 12'd120;
      cfg_r.angle_tolerance   <= 10'd16;
      cfg_r.speed_tolerance   <= 15'd720;
      cfg_r.manual_deadband   <= 15'd492;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/apsc_power_calc.sv =====
// ----------------------------------------------------------------------------
// apsc_power_calc - hold and move power arithmetic
// Gravity-feedforward hold power and clamped proportional move power, both
// rounded to nearest (ties away from zero) via constant reciprocal multiply.
// ----------------------------------------------------------------------------
module apsc_power_calc (
  input  logic signed [12:0] arm_angle,
  input  logic signed [12:0] hold_goal,
  input  logic signed [12:0] move_goal,
  input  logic        [14:0] move_limit,
  output logic signed [15:0] hold_power,
  output logic signed [15:0] move_power
);

  logic signed [13:0] hdiff;
  logic signed [24:0] hdiff_x;
  logic signed [24:0] hgoal_x;
  logic signed [24:0] hnum;
  logic        [23:0] hmag;
  logic        [23:0] hx;
  logic        [48:0] hprod;
  logic        [13:0] hq;

  logic signed [13:0] mdiff;
  logic        [13:0] mmag;
  logic        [23:0] mx;
  logic        [48:0] mprod;
  logic        [19:0] mq;
  logic signed [15:0] mlim_s;

  // Hold: (-goal*320 + (goal-angle)*1152) / 1125, magnitude stays below 2^24
  assign hdiff   = 14'(hold_goal) - 14'(arm_angle);
  assign hdiff_x = 25'(hdiff);
  assign hgoal_x = 25'(hold_goal);
  assign hnum    = hdiff_x * 25'sd1152 - hgoal_x * 25'sd320;
  assign hmag    = hnum[24] ? 24'(-hnum) : hnum[23:0];
  assign hx      = hmag + apsc_pkg::HOLD_HALF;
  assign hprod   = 49'(hx) * 49'(apsc_pkg::HOLD_RECIP);
  assign hq      = 14'(hprod >> apsc_pkg::HOLD_SHIFT);
  // |hq| stays under 9600, so no saturation stage is needed
  assign hold_power = hnum[24] ? -$signed(16'(hq)) : $signed(16'(hq));

  // Move: (goal-angle)*1024/25, clamped to the limit
  assign mdiff  = 14'(move_goal) - 14'(arm_angle);
  assign mmag   = mdiff[13] ? 14'(-mdiff) : 14'(mdiff);
  assign mx     = {mmag, 10'b0} + apsc_pkg::MOVE_HALF;
  assign mprod  = 49'(mx) * 49'(apsc_pkg::MOVE_RECIP);
  assign mq     = 20'(mprod >> apsc_pkg::MOVE_SHIFT);
  assign mlim_s = $signed(16'(move_limit));

  always_comb begin
    if (mq > 20'(move_limit)) begin
      move_power = mdiff[13] ? -mlim_s : mlim_s;
    end else begin
      move_power = mdiff[13] ? -$signed(16'(mq)) : $signed(16'(mq));
    end
  end

endmodule

// ===== rtl/core/apsc_ctrl_core.sv =====
// ----------------------------------------------------------------------------
// apsc_ctrl_core - command checker, pending request and tick state machine
// Evaluates one registered beat per cycle and updates state when it retires.
// ----------------------------------------------------------------------------
module apsc_ctrl_core (
  input  logic              clk,
  input  logic              rst_n,
  input  apsc_pkg::cfg_t    cfg,
  input  logic              fire,
  input  apsc_pkg::item_t   item,
  output apsc_pkg::result_t result
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_HOLD  = 2'd1,
    ST_MOVE  = 2'd2,
    ST_BLOCK = 2'd3
  } state_t;

  state_t             run_state_r,  run_state_nxt;
  logic        [1:0]  run_mode_r,   run_mode_nxt;
  logic        [14:0] run_limit_r,  run_limit_nxt;
  logic signed [12:0] run_goal_r,   run_goal_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  state_t             pend_state_r, pend_state_nxt;
  logic        [1:0]  pend_mode_r,  pend_mode_nxt;
  logic        [14:0] pend_limit_r, pend_limit_nxt;
  logic signed [12:0] pend_goal_r,  pend_goal_nxt;
  logic signed [15:0] prev_power_r, prev_power_nxt;
  logic signed [12:0] stop_angle_r, stop_angle_nxt;

  // Running request as seen by a tick (pending one applied)
  state_t             state_a;
  logic        [1:0]  mode_a;
  logic        [14:0] limit_a;
  logic signed [12:0] goal_a;

  logic signed [12:0] ang;
  logic               down;
  logic               in_zone;
  logic               blocked;
  logic signed [12:0] tol_goal;
  logic signed [13:0] tdiff;
  logic        [13:0] tdiff_mag;
  logic        [15:0] spd_mag;
  logic               in_tol;
  logic signed [12:0] hold_goal;
  logic signed [15:0] hold_power;
  logic signed [15:0] move_power;
  logic signed [15:0] np;
  logic        [16:0] alim;
  logic signed [16:0] lim_x;
  logic               same_req;
  logic               goal_out;
  logic               latch;
  logic        [1:0]  status;

  assign ang = item.arm_angle;

  // Apply the pending request for a tick
  always_comb begin
    if (pend_valid_r) begin
      state_a = pend_state_r;
      mode_a  = pend_mode_r;
      limit_a = pend_limit_r;
      goal_a  = pend_goal_r;
    end else begin
      state_a = run_state_r;
      mode_a  = run_mode_r;
      limit_a = run_limit_r;
      goal_a  = run_goal_r;
    end
  end

  // Blocked test against the applied goal
  assign down    = ang > goal_a;
  assign in_zone = (ang > apsc_pkg::ZONE_LOW && ang < 13'sd0) ||
                   (ang > 13'sd0 && ang < apsc_pkg::ZONE_HIGH);
  assign blocked = (ang >= cfg.max_angle && !down) ||
                   (ang < cfg.min_angle && down) ||
                   (item.lift_height >= cfg.lift_block_height && down && in_zone);

  // Tolerance window; commands see the unapplied goal
  assign tol_goal  = item.req_type ? run_goal_r : goal_a;
  assign tdiff     = 14'(tol_goal) - 14'(ang);
  assign tdiff_mag = tdiff[13] ? 14'(-tdiff) : 14'(tdiff);
  assign spd_mag   = item.arm_speed[15] ? 16'(-item.arm_speed) : 16'(item.arm_speed);
  assign in_tol    = (tdiff_mag < 14'(cfg.angle_tolerance)) &&
                     (spd_mag < 16'(cfg.speed_tolerance));

  assign hold_goal = (state_a == ST_BLOCK) ? stop_angle_r : goal_a;

  apsc_power_calc u_power (
    .arm_angle  (ang),
    .hold_goal  (hold_goal),
    .move_goal  (goal_a),
    .move_limit (limit_a),
    .hold_power (hold_power),
    .move_power (move_power)
  );

  // Command checks
  assign lim_x    = 17'(item.power_limit);
  assign alim     = lim_x[16] ? 17'(-lim_x) : 17'(lim_x);
  assign same_req = (item.cmd_mode == run_mode_r) &&
                    (item.power_limit == $signed(16'(run_limit_r))) &&
                    (item.goal_angle == run_goal_r);
  assign goal_out = (item.goal_angle < cfg.min_angle) ||
                    (item.goal_angle > cfg.max_angle);

  // Next state and result
  always_comb begin
    run_state_nxt  = run_state_r;
    run_mode_nxt   = run_mode_r;
    run_limit_nxt  = run_limit_r;
    run_goal_nxt   = run_goal_r;
    pend_valid_nxt = pend_valid_r;
    pend_state_nxt = pend_state_r;
    pend_mode_nxt  = pend_mode_r;
    pend_limit_nxt = pend_limit_r;
    pend_goal_nxt  = pend_goal_r;
    prev_power_nxt = prev_power_r;
    stop_angle_nxt = stop_angle_r;
    np             = 16'sd0;
    latch          = 1'b0;
    status         = apsc_pkg::STATUS_NONE;

    if (item.req_type) begin
      // command beat
      if (same_req) begin
        status = apsc_pkg::STATUS_UNCHANGED;
      end else begin
        pend_valid_nxt = 1'b0;
        if (alim > apsc_pkg::FULL_POWER ||
            (item.cmd_mode != apsc_pkg::MODE_MANUAL && goal_out)) begin
          status = apsc_pkg::STATUS_REJECTED;
        end else begin
          case (item.cmd_mode)
            apsc_pkg::MODE_DISABLED: begin
              latch          = 1'b1;
              pend_state_nxt = ST_IDLE;
              pend_limit_nxt = 15'd0;
              pend_goal_nxt  = 13'sd0;
            end
            apsc_pkg::MODE_AUTO: begin
              latch          = 1'b1;
              pend_state_nxt = ST_MOVE;
              pend_limit_nxt = alim[14:0];
              pend_goal_nxt  = item.goal_angle;
            end
            apsc_pkg::MODE_MANUAL: begin
              if (alim < 17'(cfg.manual_deadband)) begin
                if (run_state_r == ST_HOLD) begin
                  status = apsc_pkg::STATUS_UNCHANGED;
                end else begin
                  latch          = 1'b1;
                  pend_state_nxt = ST_HOLD;
                  pend_limit_nxt = 15'd0;
                  pend_goal_nxt  = ang;
                end
              end else begin
                latch          = 1'b1;
                pend_state_nxt = ST_MOVE;
                pend_limit_nxt = alim[14:0];
                pend_goal_nxt  = (item.power_limit > 16'sd0) ? cfg.max_angle
                                                             : cfg.min_angle;
              end
            end
            default: status = apsc_pkg::STATUS_REJECTED;
          endcase
          if (latch) begin
            pend_mode_nxt  = item.cmd_mode;
            pend_valid_nxt = 1'b1;
            status         = apsc_pkg::STATUS_ACCEPTED;
          end
        end
      end
    end else begin
      // tick beat
      run_state_nxt  = state_a;
      run_mode_nxt   = mode_a;
      run_limit_nxt  = limit_a;
      run_goal_nxt   = goal_a;
      pend_valid_nxt = 1'b0;
      case (state_a)
        ST_HOLD: np = hold_power;
        ST_MOVE: begin
          if (blocked) begin
            stop_angle_nxt = ang;
            run_state_nxt  = ST_BLOCK;
          end else if (in_tol) begin
            run_state_nxt = ST_HOLD;
          end else begin
            np = move_power;
          end
        end
        ST_BLOCK: begin
          if (!blocked) begin
            run_state_nxt = ST_MOVE;
          end else begin
            np = hold_power;
          end
        end
        default: np = 16'sd0;
      endcase
      prev_power_nxt = np;
    end

    result.motor_power   = item.req_type ? prev_power_r : np;
    result.power_changed = !item.req_type && (np != prev_power_r);
    result.at_goal       = in_tol && !pend_valid_nxt;
    result.ctrl_state    = 2'(run_state_nxt);
    result.cmd_status    = status;
  end

  // State holds until a beat retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_state_r  <= ST_IDLE;
      run_mode_r   <= apsc_pkg::MODE_DISABLED;
      run_limit_r  <= 15'd0;
      run_goal_r   <= apsc_pkg::RESET_GOAL;
      pend_valid_r <= 1'b0;
      pend_state_r <= ST_IDLE;
      pend_mode_r  <= apsc_pkg::MODE_DISABLED;
      pend_limit_r <= 15'd0;
      pend_goal_r  <= apsc_pkg::RESET_GOAL;
      prev_power_r <= 16'sd0;
      stop_angle_r <= 13'sd0;
    end else if (fire) begin
      run_state_r  <= run_state_nxt;
      run_mode_r   <= run_mode_nxt;
      run_limit_r  <= run_limit_nxt;
      run_goal_r   <= run_goal_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_state_r <= pend_state_nxt;
      pend_mode_r  <= pend_mode_nxt;
      pend_limit_r <= pend_limit_nxt;
      pend_goal_r  <= pend_goal_nxt;
      prev_power_r <= prev_power_nxt;
      stop_angle_r <= stop_angle_nxt;
    end
  end

  // A tick always consumes the pending request
  a_tick_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.req_type |=> !pend_valid_r)
    else $error("pending request survived a tick");

  // Only a disabled request leaves the arm idle
  a_idle_iff_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (run_state_r == ST_IDLE) == (run_mode_r == apsc_pkg::MODE_DISABLED))
    else $error("run state and run mode disagree");

  // A pending request never asks for the blocked state
  a_pend_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> pend_state_r != ST_BLOCK)
    else $error("pending request in blocked state");

  // Command beats leave the drive power alone
  a_cmd_keeps_power: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.req_type |=> $stable(prev_power_r))
    else $error("command beat changed power");

  // Drive power stays within full scale
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    prev_power_r <= 16'sd16384 && prev_power_r >= -16'sd16384)
    else $error("power outside full scale");

endmodule

// ===== rtl/core/arm_position_state_controller.sv =====
// ----------------------------------------------------------------------------
// arm_position_state_controller - arm position controller top level
// Command beats set a pending request; tick beats run the arm state machine.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready beats; req_type 1 is a command (mode, power limit,
//            goal), req_type 0 is a control tick with the arm sensor readings.
//   out_ch : exactly one result beat per input beat, in order: motor power,
//            changed flag, at-goal flag, controller state, command status.
//   cfg_*  : write-only registers (index 0..5); the user writes them only
//            while the block idles, and the block itself does not enforce it.
// Path: a beat passes the input register, a single compute stage and the
//   result register; one beat per cycle while out_ch takes the results.
// Stall: a full result register that out_ch does not take holds its beat;
//   the input register still takes one more beat, then in_ch.ready drops
//   until the result is taken.
// Reset (rst_n low, synchronous): both channels empty, arm idle and disabled,
//   no pending request, power zero, registers at their default values.
// ----------------------------------------------------------------------------
module arm_position_state_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  apsc_in_if.sink                         in_ch,
  apsc_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [apsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  apsc_pkg::cfg_t    cfg;
  apsc_pkg::item_t   in_item;
  apsc_pkg::item_t   s1_item_r;
  logic              s1_valid_r, s1_valid_nxt;
  apsc_pkg::result_t core_res;
  apsc_pkg::result_t out_res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_take;
  logic              s1_fire;
  logic              in_fire;

  apsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input beat
  assign in_item.req_type    = in_ch.req_type;
  assign in_item.cmd_mode    = in_ch.cmd_mode;
  assign in_item.power_limit = in_ch.power_limit;
  assign in_item.goal_angle  = in_ch.goal_angle;
  assign in_item.arm_angle   = in_ch.arm_angle;
  assign in_item.arm_speed   = in_ch.arm_speed;
  assign in_item.lift_height = in_ch.lift_height;

  // Pipeline handshake
  assign out_take    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_take;
  assign in_ch.ready = !s1_valid_r || out_take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  apsc_ctrl_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (s1_fire),
    .item   (s1_item_r),
    .result (core_res)
  );

  // Result beat
  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_power   = out_res_r.motor_power;
  assign out_ch.power_changed = out_res_r.power_changed;
  assign out_ch.at_goal       = out_res_r.at_goal;
  assign out_ch.ctrl_state    = out_res_r.ctrl_state;
  assign out_ch.cmd_status    = out_res_r.cmd_status;

endmodule

// ===== tb/apsc_result_checker.sv =====
// ----------------------------------------------------------------------------
// apsc_result_checker - result checker for the arm position state controller
// Watches the register port and both channels, keeps its own copy of the arm
// controller state, predicts one result per accepted input beat and compares
// every result beat field by field in order.
// ----------------------------------------------------------------------------
module apsc_result_checker
  import apsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  apsc_in_if                    in_ch,
  apsc_out_if                   out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // controller states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HOLD  = 2'd1;
  localparam logic [1:0] ST_MOVE  = 2'd2;
  localparam logic [1:0] ST_BLOCK = 2'd3;

  localparam int FULL       = FULL_POWER;
  localparam int Z_LO       = ZONE_LOW;
  localparam int Z_HI       = ZONE_HIGH;

  // register copy and controller state
  cfg_t               regs;
  logic [1:0]         run_state, run_mode, pend_state, pend_mode;
  logic signed [15:0] run_limit, pend_limit, last_power;
  logic signed [12:0] run_goal, pend_goal, stop_angle;
  logic               pend_valid;

  result_t            due_results[$];
  int                 fails;

  function automatic void clear_model();
    regs = '{min_angle: -13'sd1440, max_angle: 13'sd1440, lift_block_height: 12'd120,
             angle_tolerance: 10'd16, speed_tolerance: 15'd720,
             manual_deadband: 15'd492};
    run_state  = ST_IDLE;
    run_mode   = MODE_DISABLED;
    run_limit  = '0;
    run_goal   = RESET_GOAL;
    pend_valid = 1'b0;
    pend_state = ST_IDLE;
    pend_mode  = MODE_DISABLED;
    pend_limit = '0;
    pend_goal  = RESET_GOAL;
    last_power = '0;
    stop_angle = '0;
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // round to nearest, ties away from zero
  function automatic int round_div(input longint num, input longint den);
    if (num >= 0) return int'((num + den / 2) / den);
    return -int'((-num + den / 2) / den);
  endfunction

  function automatic int clamp_power(input int p);
    if (p > FULL) return FULL;
    if (p < -FULL) return -FULL;
    return p;
  endfunction

  // angle limits, plus the downward zones while the lift is high
  function automatic bit arm_blocked(input int ang, input int goal, input int lift);
    bit down;
    int lo, hi;
    down = ang > goal;
    lo = $signed(regs.min_angle);
    hi = $signed(regs.max_angle);
    if ((ang >= hi && !down) || (ang < lo && down)) return 1'b1;
    if (lift >= int'(regs.lift_block_height) && down)
      return (ang > Z_LO && ang < 0) || (ang > 0 && ang < Z_HI);
    return 1'b0;
  endfunction

  // gravity feedforward plus proportional term
  function automatic int hold_power(input int ang, input int goal);
    longint num;
    num = -longint'(goal) * 320 + (longint'(goal) - ang) * 1152;
    return clamp_power(round_div(num, 1125));
  endfunction

  function automatic int move_power(input int ang, input int goal, input int limit);
    int p;
    p = round_div((longint'(goal) - ang) * 1024, 25);
    if (mag(p) > limit) p = (ang > goal) ? -limit : limit;
    return clamp_power(p);
  endfunction

  function automatic bit goal_reached(input int ang, input int spd);
    if (pend_valid) return 1'b0;
    return mag(int'(run_goal) - ang) < int'(regs.angle_tolerance) &&
           mag(spd) < int'(regs.speed_tolerance);
  endfunction

  // command check and latch of the pending request
  function automatic logic [1:0] take_command(input logic [1:0] mode, input int lim,
                                              input int goal, input int ang);
    int alim, lo, hi;
    alim = mag(lim);
    lo = $signed(regs.min_angle);
    hi = $signed(regs.max_angle);
    if (mode == run_mode && lim == int'(run_limit) && goal == int'(run_goal))
      return STATUS_UNCHANGED;
    pend_valid = 1'b0;
    if (alim > FULL) return STATUS_REJECTED;
    if (mode != MODE_MANUAL && (goal < lo || goal > hi)) return STATUS_REJECTED;
    case (mode)
      MODE_DISABLED: begin
        pend_state = ST_IDLE;
        pend_limit = '0;
        pend_goal  = '0;
      end
      MODE_AUTO: begin
        pend_state = ST_MOVE;
        pend_limit = 16'(alim);
        pend_goal  = 13'(goal);
      end
      MODE_MANUAL: begin
        if (alim < int'(regs.manual_deadband)) begin
          if (run_state == ST_HOLD) return STATUS_UNCHANGED;
          pend_state = ST_HOLD;
          pend_limit = '0;
          pend_goal  = 13'(ang);
        end else begin
          pend_state = ST_MOVE;
          pend_limit = 16'(alim);
          pend_goal  = (lim > 0) ? regs.max_angle : regs.min_angle;
        end
      end
      default: return STATUS_REJECTED;
    endcase
    pend_mode  = mode;
    pend_valid = 1'b1;
    return STATUS_ACCEPTED;
  endfunction

  // one input beat in, one result out
  function automatic result_t step_controller(input item_t b);
    int ang, spd, lift, np;
    result_t r;
    ang  = $signed(b.arm_angle);
    spd  = $signed(b.arm_speed);
    lift = b.lift_height;
    r.motor_power   = last_power;
    r.power_changed = 1'b0;
    r.cmd_status    = STATUS_NONE;
    if (b.req_type) begin
      r.cmd_status = take_command(b.cmd_mode, $signed(b.power_limit),
                                  $signed(b.goal_angle), ang);
    end else begin
      np = 0;
      if (pend_valid) begin
        run_state  = pend_state;
        run_mode   = pend_mode;
        run_limit  = pend_limit;
        run_goal   = pend_goal;
        pend_valid = 1'b0;
      end
      case (run_state)
        ST_HOLD: np = hold_power(ang, run_goal);
        ST_MOVE: begin
          if (arm_blocked(ang, run_goal, lift)) begin
            stop_angle = 13'(ang);
            run_state  = ST_BLOCK;
          end else if (goal_reached(ang, spd)) begin
            run_state = ST_HOLD;
          end else begin
            np = move_power(ang, run_goal, run_limit);
          end
        end
        ST_BLOCK: begin
          if (!arm_blocked(ang, run_goal, lift)) run_state = ST_MOVE;
          else np = hold_power(ang, stop_angle);
        end
        default: np = 0;
      endcase
      r.power_changed = (np != int'(last_power));
      last_power      = 16'(np);
      r.motor_power   = 16'(np);
    end
    r.at_goal    = goal_reached(ang, spd);
    r.ctrl_state = run_state;
    return r;
  endfunction

  task automatic report(input string field, input int want, input int got);
    fails++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // register writes, result compare, then prediction of the new beat
  always @(posedge clk) begin : watch
    item_t   beat;
    result_t seen, want;
    if (!rst_n) begin
      clear_model();
      due_results.delete();
      fails = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIN_ANGLE:     regs.min_angle         = cfg_wdata[12:0];
          CFG_MAX_ANGLE:     regs.max_angle         = cfg_wdata[12:0];
          CFG_LIFT_BLOCK:    regs.lift_block_height = cfg_wdata[11:0];
          CFG_ANGLE_TOL:     regs.angle_tolerance   = cfg_wdata[9:0];
          CFG_SPEED_TOL:     regs.speed_tolerance   = cfg_wdata[14:0];
          CFG_MANUAL_DEADBD: regs.manual_deadband   = cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.motor_power   = out_ch.motor_power;
        seen.power_changed = out_ch.power_changed;
        seen.at_goal       = out_ch.at_goal;
        seen.ctrl_state    = out_ch.ctrl_state;
        seen.cmd_status    = out_ch.cmd_status;
        if (due_results.size() == 0) begin
          fails++;
          $error("result beat with no result due");
        end else begin
          want = due_results.pop_front();
          if (seen.motor_power !== want.motor_power)
            report("motor_power", want.motor_power, seen.motor_power);
          if (seen.power_changed !== want.power_changed)
            report("power_changed", want.power_changed, seen.power_changed);
          if (seen.at_goal !== want.at_goal)
            report("at_goal", want.at_goal, seen.at_goal);
          if (seen.ctrl_state !== want.ctrl_state)
            report("ctrl_state", want.ctrl_state, seen.ctrl_state);
          if (seen.cmd_status !== want.cmd_status)
            report("cmd_status", want.cmd_status, seen.cmd_status);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        beat.req_type    = in_ch.req_type;
        beat.cmd_mode    = in_ch.cmd_mode;
        beat.power_limit = in_ch.power_limit;
        beat.goal_angle  = in_ch.goal_angle;
        beat.arm_angle   = in_ch.arm_angle;
        beat.arm_speed   = in_ch.arm_speed;
        beat.lift_height = in_ch.lift_height;
        due_results.push_back(step_controller(beat));
      end
    end
    fail_count <= fails;
    awaiting   <= due_results.size();
  end

endmodule

// ===== tb/arm_position_state_controller_test.sv =====
// ----------------------------------------------------------------------------
// arm_position_state_controller_test - testbench top of the arm controller
// Drives command and tick beats with random gaps and result back-pressure
// across several register settings; the result checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module arm_position_state_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import apsc_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int PRESSURE_CYCLES = 60;

  localparam bit         REQ_TICK    = 1'b0;
  localparam bit         REQ_CMD     = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    awaiting;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  bit                    hold_request;
  int                    hold_left;
  int                    quiet;
  cfg_t                  limits;

  apsc_in_if  in_ch();
  apsc_out_if out_ch();

  arm_position_state_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  apsc_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("arm_position_state_controller: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic cfg_t settings(input int lo, input int hi, input int lift,
                                    input int atol, input int stol, input int dead);
    cfg_t s;
    s.min_angle         = 13'(lo);
    s.max_angle         = 13'(hi);
    s.lift_block_height = 12'(lift);
    s.angle_tolerance   = 10'(atol);
    s.speed_tolerance   = 15'(stol);
    s.manual_deadband   = 15'(dead);
    return s;
  endfunction

  function automatic item_t beat(input bit req, input logic [1:0] mode, input int lim,
                                 input int goal, input int ang, input int spd,
                                 input int lift);
    item_t b;
    b.req_type    = req;
    b.cmd_mode    = mode;
    b.power_limit = 16'(lim);
    b.goal_angle  = 13'(goal);
    b.arm_angle   = 13'(ang);
    b.arm_speed   = 16'(spd);
    b.lift_height = 12'(lift);
    return b;
  endfunction

  function automatic item_t noise_beat();
    item_t b;
    b.req_type    = 1'($urandom);
    b.cmd_mode    = 2'($urandom);
    b.power_limit = 16'($urandom);
    b.goal_angle  = 13'($urandom);
    b.arm_angle   = 13'($urandom);
    b.arm_speed   = 16'($urandom);
    b.lift_height = 12'($urandom);
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_beat(input item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= b.req_type;
    in_ch.cmd_mode    <= b.cmd_mode;
    in_ch.power_limit <= b.power_limit;
    in_ch.goal_angle  <= b.goal_angle;
    in_ch.arm_angle   <= b.arm_angle;
    in_ch.arm_speed   <= b.arm_speed;
    in_ch.lift_height <= b.lift_height;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    put_reg(CFG_MIN_ANGLE, s.min_angle);
    put_reg(CFG_MAX_ANGLE, s.max_angle);
    put_reg(CFG_LIFT_BLOCK, s.lift_block_height);
    put_reg(CFG_ANGLE_TOL, s.angle_tolerance);
    put_reg(CFG_SPEED_TOL, s.speed_tolerance);
    put_reg(CFG_MANUAL_DEADBD, s.manual_deadband);
    cfg_wr_en <= 1'b0;
    limits = s;
  endtask

  // mostly a command followed by ticks that walk the arm toward its goal
  task automatic run_traffic(input int count);
    item_t b, cmd;
    int sent, roll, aim, ang, lim, lo, hi, dead, th, spd_w, ticks;
    bit again;
    sent  = 0;
    lo    = $signed(limits.min_angle);
    hi    = $signed(limits.max_angle);
    dead  = limits.manual_deadband;
    th    = limits.lift_block_height;
    spd_w = (limits.speed_tolerance + 20 > 32767) ? 32767 : limits.speed_tolerance + 20;
    while (sent < count) begin
      roll = $urandom_range(99);
      b    = noise_beat();
      if (roll < 12) begin
        send_beat(b);
        sent++;
      end else begin
        b.req_type   = REQ_CMD;
        b.goal_angle = 13'((lo <= hi) ? span(lo, hi) : span(-4096, 4095));
        lim          = span(-16384, 16384);
        if (roll < 50) begin
          b.cmd_mode = MODE_AUTO;
        end else if (roll < 75) begin
          b.cmd_mode = MODE_MANUAL;
          if ($urandom_range(1) && dead > 0) lim = span(-(dead - 1), dead - 1);
        end else if (roll < 84) begin
          b.cmd_mode = MODE_DISABLED;
        end else if (roll < 88) begin
          b.cmd_mode = MODE_UNUSED;
        end else begin
          // out-of-range goal or power limit
          b.cmd_mode = $urandom_range(1) ? MODE_AUTO : MODE_DISABLED;
          if (hi < 4095 && $urandom_range(1)) b.goal_angle = 13'(span(hi + 1, 4095));
          else if (lo > -4096 && $urandom_range(1)) b.goal_angle = 13'(span(-4096, lo - 1));
          else lim = $urandom_range(1) ? span(16385, 32767) : span(-32768, -16385);
        end
        b.power_limit = 16'(lim);
        aim = $signed(b.goal_angle);
        if (b.cmd_mode == MODE_MANUAL)
          aim = (((lim < 0) ? -lim : lim) < dead) ? $signed(b.arm_angle) :
                ((lim > 0) ? hi : lo);
        cmd   = b;
        again = ($urandom_range(4) == 0);
        send_beat(cmd);
        sent++;
        ticks = span(1, 12);
        ang   = aim + span(-700, 700);
        for (int t = 0; t < ticks && sent < count; t++) begin
          b          = noise_beat();
          b.req_type = REQ_TICK;
          ang        = ang + (aim - ang) / 2 + span(-3, 3);
          if (ang > 4095) ang = 4095;
          if (ang < -4096) ang = -4096;
          b.arm_angle = 13'(ang);
          if ($urandom_range(9) < 7) b.arm_speed = 16'(span(-spd_w, spd_w));
          b.lift_height = 12'($urandom_range(1) ? span(th, 4095) :
                              span(0, (th > 0) ? th - 1 : 0));
          send_beat(b);
          sent++;
          // same command again once it has been applied
          if (t == 0 && again) begin
            send_beat(cmd);
            sent++;
          end
        end
      end
    end
  endtask

  task automatic run_phase(input cfg_t s, input int idle_pct, input int stall_pct,
                           input int count, input bit squeeze);
    while (awaiting != 0) @(negedge clk);
    load_settings(s);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (squeeze) hold_request = 1'b1;
    run_traffic(count);
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = 1'b0;
    in_ch.cmd_mode    = '0;
    in_ch.power_limit = '0;
    in_ch.goal_angle  = '0;
    in_ch.arm_angle   = '0;
    in_ch.arm_speed   = '0;
    in_ch.lift_height = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 1'b0;
    hold_left         = 0;
    limits            = settings(-1440, 1440, 120, 16, 720, 492);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed beats at the reset settings
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 0, 0, 0));
    send_beat(beat(REQ_CMD, MODE_AUTO, 16384, 1440, 0, 0, 0));
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 0, 0, 0));      // move, clamped
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 1440, 0, 0));   // at upper limit
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 1440, 0, 0));   // blocked hold
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 1400, 0, 0));   // unblocked
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 1438, 0, 0));   // at goal
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 1438, 719, 0)); // holding
    send_beat(beat(REQ_CMD, MODE_AUTO, 16384, 1440, 1438, 0, 0)); // same request
    send_beat(beat(REQ_CMD, MODE_AUTO, -32768, 0, 0, 0, 0));      // limit too big
    send_beat(beat(REQ_CMD, MODE_AUTO, 100, 4095, 0, 0, 0));      // goal too high
    send_beat(beat(REQ_CMD, MODE_UNUSED, 100, 0, 0, 0, 0));
    send_beat(beat(REQ_CMD, MODE_MANUAL, 100, 0, 0, 0, 0));       // already holding
    send_beat(beat(REQ_CMD, MODE_MANUAL, -16384, -4096, 0, 0, 0));
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 200, 0, 4095)); // upper lift zone
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, -100, 0, 4095)); // lower lift zone
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 0, 0, 4095));   // between zones
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, -1500, 0, 0));
    send_beat(beat(REQ_CMD, MODE_DISABLED, 0, 0, 0, 0, 0));
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 0, 0, 0));
    send_beat(beat(REQ_CMD, MODE_MANUAL, 0, 0, -4096, 0, 0));     // hold where it is
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, -4096, -32768, 0));
    send_beat(beat(REQ_TICK, MODE_DISABLED, 0, 0, 4095, 32767, 4095));
    send_beat(beat(REQ_CMD, MODE_AUTO, 16384, -1441, 0, 0, 0));   // goal too low
    in_ch.valid <= 1'b0;

    run_phase(settings(-1440, 1440, 120, 16, 720, 492), 0, 0, 300, 1'b1);
    run_phase(settings(-4096, 4095, 0, 1023, 32767, 16384), 53, 0, 200, 1'b0);
    run_phase(settings(4095, -4096, 4095, 0, 0, 0), 0, 53, 100, 1'b0);
    run_phase(settings(-span(200, 2000), span(200, 2000), span(0, 300), span(1, 64),
                       span(50, 2000), span(0, 3000)), 17, 17, 275, 1'b0);
    run_phase(settings(-span(200, 2000), span(200, 2000), span(0, 300), span(1, 64),
                       span(50, 2000), span(0, 3000)), 0, 0, 275, 1'b1);

    while (awaiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("arm_position_state_controller: match");
    end else begin
      $display("arm_position_state_controller: mismatch");
    end
    $finish;
  end

endmodule
